// ===== hdl/ths_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the typed handle slot table.
// No dependencies; ths_scan and the top level import this package.
package ths_pkg;

    localparam int KINDS_DEF    = 12;
    localparam int SLOTS_DEF    = 256;
    localparam int ID_WIDTH_DEF = 32;

    localparam int KIND_W       = 4;
    localparam int SLOT_FIELD_W = 8;
    localparam int ID_FIELD_W   = 32;
    localparam int LIVE_FIELD_W = 12;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_FIND   = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_TAKE   = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_MISS   = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    typedef struct packed {
        logic [1:0]              opcode;
        logic [KIND_W-1:0]       kind;
        logic [SLOT_FIELD_W-1:0] slot;
    } t_req;

    typedef struct packed {
        logic [1:0]              status;
        logic [ID_FIELD_W-1:0]   object_id;
        logic [ID_FIELD_W-1:0]   displaced_id;
        logic [KIND_W-1:0]       taken_kind;
        logic [SLOT_FIELD_W-1:0] taken_slot;
        logic [LIVE_FIELD_W-1:0] live_total;
    } t_rsp;

    // Commands from the controller to the scan cursor.
    typedef struct packed {
        logic start;  // issue the hint position, cursor moves past it
        logic adv;    // issue the cursor position and step it
        logic ins;    // an insert landed; pull the hint down if needed
        logic take;   // the checked entry was taken; hint moves there
    } t_scan_cmd;

endpackage

// ===== hdl/ths_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ths_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/ths_scan.sv =====
`timescale 1ns / 1ps
// Scan cursor for take-next: walks entries in kind-then-slot order and
// keeps a hint below which every entry is known empty. Uses ths_pkg.
module ths_scan #(
    parameter int KINDS = 12,
    parameter int SLOTS = 256,
    localparam int ADDR_W = (KINDS * SLOTS > 1) ? $clog2(KINDS * SLOTS) : 1,
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ths_pkg::t_scan_cmd        i_cmd,
    input  logic [ADDR_W-1:0]         i_ins_addr,
    input  logic [ths_pkg::KIND_W-1:0] i_ins_kind,
    input  logic [SLOT_W-1:0]         i_ins_slot,
    output logic [ADDR_W-1:0]         o_issue_addr,
    output logic [ADDR_W-1:0]         o_chk_addr,
    output logic [ths_pkg::KIND_W-1:0] o_chk_kind,
    output logic [SLOT_W-1:0]         o_chk_slot
);
    import ths_pkg::*;

    localparam int POS_W = ADDR_W + KIND_W + SLOT_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(KINDS * SLOTS - 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    logic [ADDR_W-1:0] r_hint_addr, r_cur_addr, r_chk_addr;
    logic [KIND_W-1:0] r_hint_kind, r_cur_kind, r_chk_kind;
    logic [SLOT_W-1:0] r_hint_slot, r_cur_slot, r_chk_slot;
    logic [POS_W-1:0]  from_hint, from_cur;

    // Next position in kind-then-slot order; the last entry holds.
    function automatic logic [POS_W-1:0] f_step(input logic [ADDR_W-1:0] a,
                                                input logic [KIND_W-1:0] k,
                                                input logic [SLOT_W-1:0] s);
        logic [POS_W-1:0] res;
        res = {a, k, s};
        if (a != LAST_ADDR) begin
            if (s == LAST_SLOT) begin
                res = {a + ADDR_W'(1), k + KIND_W'(1), SLOT_W'(0)};
            end else begin
                res = {a + ADDR_W'(1), k, s + SLOT_W'(1)};
            end
        end
        return res;
    endfunction

    assign from_hint = f_step(r_hint_addr, r_hint_kind, r_hint_slot);
    assign from_cur  = f_step(r_cur_addr, r_cur_kind, r_cur_slot);

    assign o_issue_addr = i_cmd.start ? r_hint_addr : r_cur_addr;
    assign o_chk_addr   = r_chk_addr;
    assign o_chk_kind   = r_chk_kind;
    assign o_chk_slot   = r_chk_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hint_addr <= '0;
            r_hint_kind <= '0;
            r_hint_slot <= '0;
        end else if (i_cmd.take) begin
            r_hint_addr <= r_chk_addr;
            r_hint_kind <= r_chk_kind;
            r_hint_slot <= r_chk_slot;
        end else if (i_cmd.ins && (i_ins_addr < r_hint_addr)) begin
            r_hint_addr <= i_ins_addr;
            r_hint_kind <= i_ins_kind;
            r_hint_slot <= i_ins_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            {r_chk_addr, r_chk_kind, r_chk_slot} <= {r_hint_addr, r_hint_kind, r_hint_slot};
            {r_cur_addr, r_cur_kind, r_cur_slot} <= from_hint;
        end else if (i_cmd.adv) begin
            {r_chk_addr, r_chk_kind, r_chk_slot} <= {r_cur_addr, r_cur_kind, r_cur_slot};
            {r_cur_addr, r_cur_kind, r_cur_slot} <= from_cur;
        end
    end

endmodule

// ===== hdl/typed_handle_slot_table.sv =====
`timescale 1ns / 1ps
// Top level of the typed handle slot table: controller, id counter, live
// counter and result register. Uses ths_pkg, ths_ram and ths_scan.
//
// The table holds KINDS*SLOTS ids in one RAM with a registered read.
// After reset a clearing pass writes zero to every entry, one per
// cycle, and the block takes no request until that pass is done. For
// insert, find and remove the RAM read is issued in the cycle the request
// is accepted; the write-back and result follow in the write-back state,
// which waits until the output register is free. Take-next reads one
// entry per cycle starting at a hint position below which all entries
// are known empty, passing over empty entries until it reaches a live
// one, which it takes; on an empty table it answers from the live counter
// without a scan.
// One request is in flight at a time. The result sits in an output
// register, so a new request is accepted while the previous result still
// waits to be taken; the block then holds its write-back until the output
// register frees up.
module typed_handle_slot_table #(
    parameter int KINDS    = ths_pkg::KINDS_DEF,
    parameter int SLOTS    = ths_pkg::SLOTS_DEF,
    parameter int ID_WIDTH = ths_pkg::ID_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  ths_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output ths_pkg::t_rsp o_rsp
);
    import ths_pkg::*;

    localparam int ENTRY_COUNT = KINDS * SLOTS;
    localparam int ADDR_W      = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LIVE_W      = $clog2(ENTRY_COUNT + 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ENTRY_COUNT - 1);

    // Controller states.
    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_EXEC  = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [ADDR_W-1:0]   r_clr_addr, n_clr_addr;
    logic [ID_WIDTH-1:0] r_next_id, n_next_id;
    logic [LIVE_W-1:0]   r_live, n_live;
    logic                r_out_valid, n_out_valid;
    t_rsp                r_out, n_out;

    // Request held for the write-back cycle.
    t_req                r_req;
    logic                r_ok;
    logic [ADDR_W-1:0]   r_addr;

    logic                accept;
    logic                out_free;
    logic                req_ok;
    logic [ADDR_W-1:0]   req_idx;

    logic                ram_we, ram_re;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [ID_WIDTH-1:0] ram_wdata, ram_rdata;

    t_scan_cmd           scan_cmd;
    logic [ADDR_W-1:0]   scan_issue, scan_chk_addr;
    logic [KIND_W-1:0]   scan_chk_kind;
    logic [SLOT_W-1:0]   scan_chk_slot;

    t_rsp                rsp;

    assign o_req_ready = (r_state == S_IDLE);
    assign accept      = i_req_valid && o_req_ready;
    assign out_free    = !r_out_valid || i_rsp_ready;
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    // Entry address: kind * SLOTS + slot, a multiply by a small constant.
    // Out-of-range inserts, finds and removes read entry zero and are answered without a write.
    assign req_ok = ({1'b0, i_req.kind} < (KIND_W + 1)'(KINDS)) &&
                    ({5'b0, i_req.slot} < 13'(SLOTS));
    assign req_idx = req_ok ?
        ADDR_W'(ADDR_W'(i_req.kind) * ADDR_W'(SLOTS) + ADDR_W'(i_req.slot)) : '0;

    // Plain requests read their own entry; a take-next reads where the
    // scan cursor points.
    assign ram_raddr = ((r_state == S_IDLE) && (i_req.opcode != OP_TAKE)) ?
                       req_idx : scan_issue;

    ths_ram #(
        .WIDTH (ID_WIDTH),
        .DEPTH (ENTRY_COUNT)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ths_scan #(
        .KINDS (KINDS),
        .SLOTS (SLOTS)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (scan_cmd),
        .i_ins_addr   (r_addr),
        .i_ins_kind   (r_req.kind),
        .i_ins_slot   (SLOT_W'(r_req.slot)),
        .o_issue_addr (scan_issue),
        .o_chk_addr   (scan_chk_addr),
        .o_chk_kind   (scan_chk_kind),
        .o_chk_slot   (scan_chk_slot)
    );

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_next_id   = r_next_id;
        n_live      = r_live;
        n_out_valid = r_out_valid && !i_rsp_ready;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = r_addr;
        ram_wdata   = '0;
        ram_re      = 1'b0;
        scan_cmd    = '0;
        rsp         = '0;

        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + ADDR_W'(1);
                end
            end
            S_IDLE: begin
                if (accept) begin
                    ram_re = 1'b1;
                    if ((i_req.opcode == OP_TAKE) && (r_live != '0)) begin
                        scan_cmd.start = 1'b1;
                        n_state        = S_SCAN;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_SCAN: begin
                // Keep reading while the checked entry is empty. A live
                // entry exists since the live count is nonzero.
                if (ram_rdata == '0) begin
                    ram_re       = 1'b1;
                    scan_cmd.adv = 1'b1;
                end else begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    case (r_req.opcode)
                        OP_INSERT: begin
                            if (!r_ok || (&r_next_id)) begin
                                rsp.status = ST_REJECT;
                            end else begin
                                rsp.status       = ST_OK;
                                rsp.object_id    = ID_FIELD_W'(r_next_id);
                                rsp.displaced_id = ID_FIELD_W'(ram_rdata);
                                ram_we           = 1'b1;
                                ram_wdata        = r_next_id;
                                n_next_id        = r_next_id + ID_WIDTH'(1);
                                scan_cmd.ins     = 1'b1;
                                if (ram_rdata == '0) begin
                                    n_live = r_live + LIVE_W'(1);
                                end
                            end
                        end
                        OP_FIND, OP_REMOVE: begin
                            if (!r_ok || (ram_rdata == '0)) begin
                                rsp.status = ST_MISS;
                            end else begin
                                rsp.status    = ST_OK;
                                rsp.object_id = ID_FIELD_W'(ram_rdata);
                                if (r_req.opcode == OP_REMOVE) begin
                                    ram_we = 1'b1;
                                    if (r_live != '0) begin
                                        n_live = r_live - LIVE_W'(1);
                                    end
                                end
                            end
                        end
                        default: begin
                            if (r_live == '0) begin
                                rsp.status = ST_MISS;
                            end else begin
                                rsp.status     = ST_OK;
                                rsp.object_id  = ID_FIELD_W'(ram_rdata);
                                rsp.taken_kind = scan_chk_kind;
                                rsp.taken_slot = SLOT_FIELD_W'(scan_chk_slot);
                                ram_we         = 1'b1;
                                ram_waddr      = scan_chk_addr;
                                scan_cmd.take  = 1'b1;
                                n_live         = r_live - LIVE_W'(1);
                            end
                        end
                    endcase
                    rsp.live_total = LIVE_FIELD_W'(n_live);
                    n_out          = rsp;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_next_id   <= ID_WIDTH'(1);
            r_live      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_next_id   <= n_next_id;
            r_live      <= n_live;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (accept) begin
            r_req  <= i_req;
            r_ok   <= req_ok;
            r_addr <= req_idx;
        end
    end

`ifndef SYNTH
    // The store is written only by the clearing pass or a write-back.
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ((r_state == S_CLEAR) || (r_state == S_EXEC)))
        else $error("table written outside clear or write-back");

    // The live count never exceeds the number of entries.
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= LIVE_W'(ENTRY_COUNT))
        else $error("live count above table size");

    // A scan only runs while some entry is live.
    a_scan_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_live != '0))
        else $error("scan running on an empty table");

    // A new result appears only from a write-back cycle.
    a_rsp_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_out_valid && !(r_out_valid && !i_rsp_ready)) |-> (r_state == S_EXEC))
        else $error("result loaded outside write-back");

    // The id counter never hands out zero.
    a_id_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_id != '0)
        else $error("id counter reached zero");
`endif

endmodule
